FILE: rtl/rsk_pkg.sv
package rsk_pkg;

    localparam int RECORDS = 16;
    localparam int IDX_W = $clog2(RECORDS);
    localparam int CNT_W = $clog2(RECORDS + 1);
    localparam int REC_W = 64 + 64 + 32 + 32 + 10;

    localparam logic [1:0] KEY_NAME  = 2'd0;
    localparam logic [1:0] KEY_ID    = 2'd1;
    localparam logic [1:0] KEY_GRADE = 2'd2;

    typedef struct packed {
        logic [63:0] name_high;
        logic [63:0] name_middle;
        logic [31:0] name_low;
        logic [31:0] id;
        logic [9:0]  grade;
    } record_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_from_input;
        logic             wr_from_a;
        logic [IDX_W-1:0] rd_addr;
        logic             load_a;
        logic             load_b;
        logic             emit;
        logic             emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic greater;
    } dp_status_t;

    function automatic logic name_greater(input logic [159:0] a, input logic [159:0] b);
        logic res;
        logic done;
        logic [7:0] x;
        logic [7:0] y;
        res = 1'b0;
        done = 1'b0;
        for (int k = 0; k < 20; k++)
        begin
            x = a[159 - 8*k -: 8];
            y = b[159 - 8*k -: 8];
            if (!done)
            begin
                if (x != y)
                begin
                    res = (x > y);
                    done = 1'b1;
                end
                else if (x == 8'd0)
                begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/rsk_ram.sv
module rsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/rsk_datapath.sv
module rsk_datapath
    import rsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [1:0]  key_sel,
    input  record_t     in_rec,
    output logic [63:0] sorted_name_high,
    output logic [63:0] sorted_name_middle,
    output logic [31:0] sorted_name_low,
    output logic signed [31:0] sorted_id,
    output logic [9:0]  sorted_grade,
    output logic        sorted_last,
    output logic        result_valid
);

    record_t rd_data;
    record_t wr_data;
    record_t a_reg;
    record_t b_reg;
    record_t out_reg;
    logic    last_reg;
    logic    valid_reg;
    logic    greater_reg;
    logic    greater_next;

    assign wr_data = cmd.wr_from_input ? in_rec : (cmd.wr_from_a ? a_reg : b_reg);

    rsk_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (key_sel)
            KEY_NAME:  greater_next = name_greater({a_reg.name_high, a_reg.name_middle,
                                      a_reg.name_low}, {b_reg.name_high, b_reg.name_middle,
                                      b_reg.name_low});
            KEY_ID:    greater_next = $signed(a_reg.id) > $signed(b_reg.id);
            KEY_GRADE: greater_next = a_reg.grade > b_reg.grade;
            default:   greater_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            a_reg <= rd_data;
        end
        if (cmd.load_b)
        begin
            b_reg <= rd_data;
        end
        if (cmd.emit)
        begin
            out_reg <= rd_data;
        end
        greater_reg <= greater_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            last_reg  <= cmd.emit_last;
        end
    end

    assign status.greater     = greater_reg;
    assign sorted_name_high   = out_reg.name_high;
    assign sorted_name_middle = out_reg.name_middle;
    assign sorted_name_low    = out_reg.name_low;
    assign sorted_id          = out_reg.id;
    assign sorted_grade       = out_reg.grade;
    assign sorted_last        = last_reg;
    assign result_valid       = valid_reg;

endmodule

FILE: rtl/rsk_controller.sv
module rsk_controller
    import rsk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       last_in,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDA    = 8'b0000_0010,
        S_RDB    = 8'b0000_0100,
        S_LDB    = 8'b0000_1000,
        S_CMP    = 8'b0001_0000,
        S_DEC    = 8'b0010_0000,
        S_WRB    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(RECORDS))
                    begin
                        cmd.wr_en         = 1'b1;
                        cmd.wr_addr       = count_reg[IDX_W-1:0];
                        cmd.wr_from_input = 1'b1;
                        count_next        = count_reg + 1'b1;
                    end
                    if (last_in)
                    begin
                        i_next = '0;
                        j_next = CNT_W'(1);
                        if (count_next < CNT_W'(2))
                        begin
                            state_next = (count_next == '0) ? S_IDLE : S_EMIT;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                end
            end
            S_RDA:
            begin
                cmd.rd_addr = i_reg[IDX_W-1:0];
                state_next  = S_RDB;
            end
            S_RDB:
            begin
                cmd.load_a  = 1'b1;
                cmd.rd_addr = j_reg[IDX_W-1:0];
                state_next  = S_LDB;
            end
            S_LDB:
            begin
                cmd.load_b = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (status.greater)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_addr   = i_reg[IDX_W-1:0];
                    cmd.wr_from_a = 1'b0;
                    state_next    = S_WRB;
                end
                else if (j_reg + 1'b1 < count_reg)
                begin
                    j_next      = j_reg + 1'b1;
                    cmd.rd_addr = j_next[IDX_W-1:0];
                    state_next  = S_LDB;
                end
                else if (i_reg + CNT_W'(2) < count_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + CNT_W'(2);
                    state_next = S_RDA;
                end
                else
                begin
                    i_next     = '0;
                    cmd.rd_addr = '0;
                    state_next = S_EMIT;
                end
            end
            S_WRB:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_addr   = j_reg[IDX_W-1:0];
                cmd.wr_from_a = 1'b1;
                if (j_reg + 1'b1 < count_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RDA;
                end
                else if (i_reg + CNT_W'(2) < count_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + CNT_W'(2);
                    state_next = S_RDA;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.rd_addr = i_reg[IDX_W-1:0];
                if (i_reg != '0)
                begin
                    cmd.rd_addr = i_reg[IDX_W-1:0];
                end
                state_next = S_EMIT;
                if (i_reg == count_reg)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    count_next    = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    if (i_reg != '0)
                    begin
                        cmd.emit = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        cmd.emit = (i_reg != '0);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

FILE: rtl/record_sorter_by_key.sv
// Record sorter: load records with start while busy is low, one per cycle; a
// record with last_record set starts an exchange sort of the stored set (up to
// 16 records, extras dropped) and the records then leave in key order, one per
// cycle on result_valid, sorted_last on the final one. The receiver cannot
// stall. Busy stays high from the last record until the final result is on the
// ports. Each compare loads the record at j from the record RAM (separate read
// and write ports), registers the result and decides; each outer pass first
// reads the record at i, and each swap writes both records back and re-reads the
// record at i, n*(n-1)/2 compares in all. Output then reads the records in order.
module record_sorter_by_key
    import rsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] name_high,
    input  logic [63:0] name_middle,
    input  logic [31:0] name_low,
    input  logic signed [31:0] record_id,
    input  logic [9:0]  grade_hundredths,
    input  logic        last_record,
    output logic        result_valid,
    output logic [63:0] sorted_name_high,
    output logic [63:0] sorted_name_middle,
    output logic [31:0] sorted_name_low,
    output logic signed [31:0] sorted_id,
    output logic [9:0]  sorted_grade,
    output logic        sorted_last
);

    logic [1:0] key_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    record_t    in_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_NAME;
        end
        else if (cfg_we)
        begin
            key_reg <= cfg_data;
        end
    end

    assign in_rec = '{name_high, name_middle, name_low, record_id, grade_hundredths};

    rsk_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_record),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    rsk_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .key_sel            (key_reg),
        .in_rec             (in_rec),
        .sorted_name_high   (sorted_name_high),
        .sorted_name_middle (sorted_name_middle),
        .sorted_name_low    (sorted_name_low),
        .sorted_id          (sorted_id),
        .sorted_grade       (sorted_grade),
        .sorted_last        (sorted_last),
        .result_valid       (result_valid)
    );

endmodule

FILE: tb/tb_record_sorter_by_key.sv
module tb_record_sorter_by_key
    import rsk_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] nh;
        logic [63:0] nm;
        logic [31:0] nl;
        logic [31:0] id;
        logic [9:0]  grade;
        logic        last;
    } rec_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [63:0] name_high;
    logic [63:0] name_middle;
    logic [31:0] name_low;
    logic signed [31:0] record_id;
    logic [9:0]  grade_hundredths;
    logic        last_record;
    logic        result_valid;
    logic [63:0] sorted_name_high;
    logic [63:0] sorted_name_middle;
    logic [31:0] sorted_name_low;
    logic signed [31:0] sorted_id;
    logic [9:0]  sorted_grade;
    logic        sorted_last;

    record_sorter_by_key u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .name_high(name_high), .name_middle(name_middle), .name_low(name_low),
        .record_id(record_id), .grade_hundredths(grade_hundredths),
        .last_record(last_record), .result_valid(result_valid),
        .sorted_name_high(sorted_name_high), .sorted_name_middle(sorted_name_middle),
        .sorted_name_low(sorted_name_low), .sorted_id(sorted_id),
        .sorted_grade(sorted_grade), .sorted_last(sorted_last)
    );

    rec_item_t pending_q[$];
    rec_item_t sorted_q[$];
    rec_item_t set_store[RECORDS];
    int        set_count;
    logic [1:0] sort_key;
    int        mismatches;
    int        results_seen;
    int        sets_sorted;
    logic      hold_send;
    int        burst_left;
    int        gap_left;
    logic      cfg_req;
    logic [1:0] cfg_req_data;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [159:0] name_bits(rec_item_t r);
        return {r.nh, r.nm, r.nl};
    endfunction

    function automatic logic rec_greater(rec_item_t a, rec_item_t b, logic [1:0] k);
        logic [159:0] x;
        logic [159:0] y;
        logic         res;
        logic         done;
        x = name_bits(a);
        y = name_bits(b);
        res = 1'b0;
        done = 1'b0;
        case (k)
            KEY_NAME:
            begin
                for (int i = 0; i < 20; i++)
                begin
                    if (!done)
                    begin
                        if (x[159-8*i -: 8] != y[159-8*i -: 8])
                        begin
                            res = x[159-8*i -: 8] > y[159-8*i -: 8];
                            done = 1'b1;
                        end
                        else if (x[159-8*i -: 8] == 8'd0)
                            done = 1'b1;
                    end
                end
            end
            KEY_ID: res = $signed(a.id) > $signed(b.id);
            KEY_GRADE: res = a.grade > b.grade;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    task automatic accept_record(rec_item_t r);
        rec_item_t t;
        if (set_count < RECORDS)
        begin
            set_store[set_count] = r;
            set_count++;
        end
        if (r.last)
        begin
            for (int i = 0; i < set_count; i++)
                for (int j = i + 1; j < set_count; j++)
                    if (rec_greater(set_store[i], set_store[j], sort_key))
                    begin
                        t = set_store[i];
                        set_store[i] = set_store[j];
                        set_store[j] = t;
                    end
            for (int i = 0; i < set_count; i++)
            begin
                t = set_store[i];
                t.last = (i == set_count - 1);
                sorted_q.push_back(t);
            end
            set_count = 0;
            sets_sorted++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            cfg_data <= 2'd0;
            name_high <= '0;
            name_middle <= '0;
            name_low <= '0;
            record_id <= '0;
            grade_hundredths <= '0;
            last_record <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                accept_record(pending_q.pop_front());
            cfg_we <= cfg_req;
            cfg_data <= cfg_req_data;
            if (cfg_req)
                sort_key = cfg_req_data;
            if (start && busy)
                ;
            else if (!hold_send && pending_q.size() > 0 && gap_left == 0
                     && !(start && pending_q.size() == 0))
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(12, 1);
                    if ($urandom_range(2, 0) == 0)
                        gap_left = $urandom_range(5, 1);
                end
                if (gap_left == 0)
                begin
                    burst_left--;
                    start <= 1'b1;
                    name_high <= pending_q[0].nh;
                    name_middle <= pending_q[0].nm;
                    name_low <= pending_q[0].nl;
                    record_id <= pending_q[0].id;
                    grade_hundredths <= pending_q[0].grade;
                    last_record <= pending_q[0].last;
                end
                else
                    start <= 1'b0;
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (sorted_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result id=%0d", sorted_id);
            end
            else
            begin
                rec_item_t e;
                e = sorted_q.pop_front();
                if (e.nh !== sorted_name_high || e.nm !== sorted_name_middle
                    || e.nl !== sorted_name_low || e.id !== sorted_id
                    || e.grade !== sorted_grade || e.last !== sorted_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h %0d %b, got %h %h %h %h %0d %b",
                            e.nh, e.nm, e.nl, e.id, e.grade, e.last,
                            sorted_name_high, sorted_name_middle, sorted_name_low,
                            sorted_id, sorted_grade, sorted_last);
                end
            end
        end
    end

    function automatic rec_item_t rand_rec(logic last, int mode);
        rec_item_t r;
        r.nh = {$urandom, $urandom};
        r.nm = {$urandom, $urandom};
        r.nl = $urandom;
        // narrow alphabet to force ties and embedded terminators
        if (mode == 1)
        begin
            r.nh[63:48] = {8'h41 + 8'($urandom_range(2, 0)), 8'($urandom_range(2, 0))};
        end
        r.id = (mode == 1) ? 32'($urandom_range(3, 0)) - 2 : $urandom;
        r.grade = (mode == 1) ? 10'($urandom_range(3, 0)) : 10'($urandom_range(1023, 0));
        r.last = last;
        return r;
    endfunction

    task automatic push_set(int n, int mode);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_rec(i == n - 1, mode));
    endtask

    task automatic wait_drain();
        while (pending_q.size() > 0 || start || sorted_q.size() > 0 || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_key(logic [1:0] k);
        @(posedge clk);
        cfg_req <= 1'b1;
        cfg_req_data <= k;
        @(posedge clk);
        cfg_req <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        rec_item_t r;
        rst_n = 1'b0;
        hold_send = 1'b0;
        cfg_req = 1'b0;
        cfg_req_data = 2'd0;
        sort_key = KEY_NAME;
        set_count = 0;
        mismatches = 0;
        results_seen = 0;
        sets_sorted = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: name extremes, ties, terminator, single record
        r = rand_rec(0, 0);
        r.nh = '1; r.nm = '1; r.nl = '1; r.id = 32'h7fffffff; r.grade = 10'd1000;
        pending_q.push_back(r);
        r.nh = '0; r.nm = '0; r.nl = '0; r.id = 32'h80000000; r.grade = 10'd0;
        pending_q.push_back(r);
        r.nh = 64'h4100_ffff_ffff_ffff; r.id = 32'd5;
        pending_q.push_back(r);
        r.nh = 64'h4100_0000_0000_0001; r.id = 32'd6;
        pending_q.push_back(r);
        r.nh = 64'h4142_4344_4546_4748; r.nm = '1; r.nl = 32'h0000_0001; r.last = 1'b1;
        pending_q.push_back(r);
        push_set(1, 0);
        wait_drain();

        set_key(KEY_ID);
        push_set(4, 1);
        push_set(18, 0);
        wait_drain();
        set_key(KEY_GRADE);
        push_set(16, 1);
        wait_drain();
        set_key(2'd3);
        push_set(5, 0);
        wait_drain();

        for (int p = 0; p < 8; p++)
        begin
            set_key(2'($urandom_range(3, 0)));
            for (int s = 0; s < 2; s++)
                push_set($urandom_range(10, 1), $urandom_range(1, 0));
            if (p == 4)
            begin
                while (sorted_q.size() == 0)
                    @(posedge clk);
                hold_send = 1'b1;
                while (sorted_q.size() > 0 || busy)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drain();
        end
        set_key(KEY_NAME);
        push_set(12, 1);
        wait_drain();

        $display("covered %0d sorted sets, %0d records checked, all key settings",
            sets_sorted, results_seen);
        if (mismatches == 0 && sorted_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
